/* design/swmm_pkg.sv */
// Shared constants, codes and types of the sliding-window multiset match block.
package swmm_pkg;

    // Element values index the count tables; the window stores past elements.
    localparam int VALUE_BITS  = 8;
    localparam int MAX_WINDOW  = 256;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam int PTR_BITS    = $clog2(MAX_WINDOW);
    localparam int POS_BITS    = $clog2(MAX_WINDOW + 1);

    // Field and register widths.
    localparam int OP_BITS    = 2;
    localparam int DATA_BITS  = 8;
    localparam int CFG_BITS   = 9;
    localparam int CNT_BITS   = 9;
    localparam int TOTAL_BITS = 32;
    localparam int IDX_BITS   = 1;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // Operation codes carried by an input item.
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_STREAM = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] CFG_WINDOW_LEN  = 1'b0;
    localparam logic [IDX_BITS-1:0] CFG_MIN_MATCHES = 1'b1;

    // One count table entry: pattern and window multiplicity of one value.
    typedef struct packed {
        logic [CNT_BITS-1:0] pattern;
        logic [CNT_BITS-1:0] window;
    } t_cnt_entry;

    localparam int ENTRY_BITS = $bits(t_cnt_entry);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_UPD,
        ST_ST_IN,
        ST_ST_OLD_RD,
        ST_ST_OLD_UPD,
        ST_ST_DONE
    } t_state;

endpackage

/* design/sliding_window_multiset_match.sv */
// Sliding-window multiset overlap counter: sequencer, count table and delay line.
// Items are taken only in idle, so a new item waits until the last is through. A stream item
// reads and writes back its count entry and, once the window is full, reads the oldest element
// from the delay line and updates its entry too; a load updates one entry and a clear none.
// A stream result waits in ST_ST_DONE and enters the output register once that is free.
// Reset (synchronous, active low) empties the count table through per-entry valid bits,
// zeroes overlap, position, total and write pointer, and sets both registers to 1.
module sliding_window_multiset_match (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [swmm_pkg::IDX_BITS-1:0]      i_cfg_idx,
    input  logic [swmm_pkg::CFG_BITS-1:0]      i_cfg_data,
    // Input channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [swmm_pkg::OP_BITS-1:0]       i_op,
    input  logic [swmm_pkg::DATA_BITS-1:0]     i_value,
    // Output channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_window_full,
    output logic                               o_window_ok,
    output logic [swmm_pkg::CNT_BITS-1:0]      o_match_count,
    output logic [swmm_pkg::TOTAL_BITS-1:0]    o_ok_windows
);

    swmm_pkg::t_state r_state;
    swmm_pkg::t_state n_state;

    // Configuration registers.
    logic [swmm_pkg::CFG_BITS-1:0] r_window_len;
    logic [swmm_pkg::CFG_BITS-1:0] r_min_matches;

    // Running state.
    logic [swmm_pkg::CNT_BITS-1:0]   r_ov;
    logic [swmm_pkg::CNT_BITS-1:0]   n_ov;
    logic [swmm_pkg::POS_BITS-1:0]   r_pos;
    logic [swmm_pkg::TOTAL_BITS-1:0] r_total;
    logic [swmm_pkg::TOTAL_BITS-1:0] n_total;
    logic [swmm_pkg::PTR_BITS-1:0]   r_wr_ptr;
    logic [swmm_pkg::TABLE_DEPTH-1:0] r_cnt_vld;
    logic [swmm_pkg::VALUE_BITS-1:0] r_val;
    logic [swmm_pkg::VALUE_BITS-1:0] r_cnt_raddr;

    // Result waiting for the output register.
    logic                            r_res_full;
    logic                            r_res_ok;
    logic [swmm_pkg::CNT_BITS-1:0]   r_res_match;
    logic [swmm_pkg::TOTAL_BITS-1:0] r_res_total;

    // Output register.
    logic                            r_o_valid;
    logic                            r_o_full;
    logic                            r_o_ok;
    logic [swmm_pkg::CNT_BITS-1:0]   r_o_match;
    logic [swmm_pkg::TOTAL_BITS-1:0] r_o_total;

    // Memory ports.
    logic                              cnt_we;
    logic                              cnt_re;
    logic [swmm_pkg::VALUE_BITS-1:0]   cnt_waddr;
    logic [swmm_pkg::VALUE_BITS-1:0]   cnt_raddr;
    swmm_pkg::t_cnt_entry              cnt_wdata;
    logic [swmm_pkg::ENTRY_BITS-1:0]   cnt_rdata;
    swmm_pkg::t_cnt_entry              cnt_q;
    logic                              dly_we;
    logic                              dly_re;
    logic [swmm_pkg::PTR_BITS-1:0]     dly_raddr;
    logic [swmm_pkg::DATA_BITS-1:0]    dly_rdata;

    // Datapath values.
    logic                              in_accept;
    logic                              out_free;
    logic [swmm_pkg::VALUE_BITS-1:0]   in_val;
    logic [swmm_pkg::VALUE_BITS-1:0]   old_val;
    logic [swmm_pkg::CFG_BITS-1:0]     wl_eff;
    logic [swmm_pkg::CFG_BITS-1:0]     wl_m1;
    logic [swmm_pkg::POS_BITS:0]       pos_inc;
    logic                              full;
    logic                              ok;
    logic [swmm_pkg::PTR_BITS-1:0]     rem_ptr;
    swmm_pkg::t_cnt_entry              upd_entry;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;
    assign in_val    = i_value[swmm_pkg::VALUE_BITS-1:0];
    assign old_val   = dly_rdata[swmm_pkg::VALUE_BITS-1:0];

    // Count table: pattern and window counts of each value side by side.
    swmm_ram #(
        .WIDTH (swmm_pkg::ENTRY_BITS),
        .DEPTH (swmm_pkg::TABLE_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Delay line of streamed elements.
    swmm_ram #(
        .WIDTH (swmm_pkg::DATA_BITS),
        .DEPTH (swmm_pkg::MAX_WINDOW)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_value),
        .i_re    (dly_re),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    // An entry not written since the last clear reads as empty.
    assign cnt_q = r_cnt_vld[r_cnt_raddr] ? swmm_pkg::t_cnt_entry'(cnt_rdata) : '0;

    // Effective window length, fullness and the slot of the oldest element.
    always_comb begin
        if (r_window_len == '0) begin
            wl_eff = swmm_pkg::CFG_BITS'(1);
        end else if (r_window_len > swmm_pkg::CFG_BITS'(swmm_pkg::MAX_WINDOW)) begin
            wl_eff = swmm_pkg::CFG_BITS'(swmm_pkg::MAX_WINDOW);
        end else begin
            wl_eff = r_window_len;
        end
        wl_m1   = wl_eff - swmm_pkg::CFG_BITS'(1);
        pos_inc = {1'b0, r_pos} + (swmm_pkg::POS_BITS + 1)'(1);
        full    = pos_inc >= (swmm_pkg::POS_BITS + 1)'(wl_eff);
        rem_ptr = r_wr_ptr - wl_m1[swmm_pkg::PTR_BITS-1:0];
    end

    // Count update of the entry read in the previous cycle.
    always_comb begin
        upd_entry = cnt_q;
        n_ov      = r_ov;
        n_total   = r_total;
        ok        = 1'b0;
        unique case (r_state)
            swmm_pkg::ST_LD_UPD: begin
                if (cnt_q.pattern < swmm_pkg::CNT_MAX) begin
                    if (cnt_q.window > cnt_q.pattern && r_ov < swmm_pkg::CNT_MAX) begin
                        n_ov = r_ov + swmm_pkg::CNT_BITS'(1);
                    end
                    upd_entry.pattern = cnt_q.pattern + swmm_pkg::CNT_BITS'(1);
                end
            end
            swmm_pkg::ST_ST_IN: begin
                if (cnt_q.window < swmm_pkg::CNT_MAX) begin
                    if (cnt_q.window < cnt_q.pattern && r_ov < swmm_pkg::CNT_MAX) begin
                        n_ov = r_ov + swmm_pkg::CNT_BITS'(1);
                    end
                    upd_entry.window = cnt_q.window + swmm_pkg::CNT_BITS'(1);
                end
                ok = full && (n_ov >= r_min_matches);
                if (ok && r_total != '1) begin
                    n_total = r_total + swmm_pkg::TOTAL_BITS'(1);
                end
            end
            swmm_pkg::ST_ST_OLD_UPD: begin
                if (cnt_q.window != '0) begin
                    if (cnt_q.window <= cnt_q.pattern && r_ov != '0) begin
                        n_ov = r_ov - swmm_pkg::CNT_BITS'(1);
                    end
                    upd_entry.window = cnt_q.window - swmm_pkg::CNT_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swmm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == swmm_pkg::OP_LOAD) begin
                        n_state = swmm_pkg::ST_LD_UPD;
                    end else if (i_op == swmm_pkg::OP_STREAM) begin
                        n_state = swmm_pkg::ST_ST_IN;
                    end
                end
            end
            swmm_pkg::ST_LD_UPD: begin
                n_state = swmm_pkg::ST_IDLE;
            end
            swmm_pkg::ST_ST_IN: begin
                n_state = full ? swmm_pkg::ST_ST_OLD_RD : swmm_pkg::ST_ST_DONE;
            end
            swmm_pkg::ST_ST_OLD_RD: begin
                n_state = swmm_pkg::ST_ST_OLD_UPD;
            end
            swmm_pkg::ST_ST_OLD_UPD: begin
                n_state = swmm_pkg::ST_ST_DONE;
            end
            swmm_pkg::ST_ST_DONE: begin
                if (out_free) begin
                    n_state = swmm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swmm_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        o_stall   = 1'b1;
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_waddr = r_val;
        cnt_raddr = in_val;
        cnt_wdata = upd_entry;
        dly_we    = 1'b0;
        dly_re    = 1'b0;
        dly_raddr = rem_ptr;
        unique case (r_state)
            swmm_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid && (i_op == swmm_pkg::OP_LOAD || i_op == swmm_pkg::OP_STREAM)) begin
                    cnt_re = 1'b1;
                end
                if (i_valid && i_op == swmm_pkg::OP_STREAM) begin
                    dly_we = 1'b1;
                end
            end
            swmm_pkg::ST_LD_UPD: begin
                cnt_we = 1'b1;
            end
            swmm_pkg::ST_ST_IN: begin
                cnt_we = 1'b1;
                dly_re = full;
            end
            swmm_pkg::ST_ST_OLD_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = old_val;
            end
            swmm_pkg::ST_ST_OLD_UPD: begin
                cnt_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= swmm_pkg::ST_IDLE;
            r_window_len  <= swmm_pkg::CFG_BITS'(1);
            r_min_matches <= swmm_pkg::CFG_BITS'(1);
            r_ov          <= '0;
            r_pos         <= '0;
            r_total       <= '0;
            r_wr_ptr      <= '0;
            r_cnt_vld     <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_total <= n_total;

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swmm_pkg::CFG_WINDOW_LEN:  r_window_len  <= i_cfg_data;
                    swmm_pkg::CFG_MIN_MATCHES: r_min_matches <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // A clear empties the tables and the running counts.
            if (in_accept && i_op == swmm_pkg::OP_CLEAR) begin
                r_cnt_vld <= '0;
                r_ov      <= '0;
                r_pos     <= '0;
                r_total   <= '0;
                r_wr_ptr  <= '0;
            end else if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end

            // Finish a stream item: advance the window and hand over the result.
            if (r_state == swmm_pkg::ST_ST_DONE && out_free) begin
                r_wr_ptr <= (r_wr_ptr == swmm_pkg::PTR_BITS'(swmm_pkg::MAX_WINDOW - 1))
                          ? '0 : r_wr_ptr + swmm_pkg::PTR_BITS'(1);
                if (r_pos < swmm_pkg::POS_BITS'(swmm_pkg::MAX_WINDOW)) begin
                    r_pos <= r_pos + swmm_pkg::POS_BITS'(1);
                end
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_val <= in_val;
        end
        if (cnt_re) begin
            r_cnt_raddr <= cnt_raddr;
        end
        if (r_state == swmm_pkg::ST_ST_OLD_RD) begin
            r_val <= old_val;
        end
        if (r_state == swmm_pkg::ST_ST_IN) begin
            r_res_full  <= full;
            r_res_ok    <= ok;
            r_res_match <= n_ov;
            r_res_total <= n_total;
        end
        if (r_state == swmm_pkg::ST_ST_DONE && out_free) begin
            r_o_full  <= r_res_full;
            r_o_ok    <= r_res_ok;
            r_o_match <= r_res_match;
            r_o_total <= r_res_total;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_window_full = r_o_full;
    assign o_window_ok   = r_o_ok;
    assign o_match_count = r_o_match;
    assign o_ok_windows  = r_o_total;

    // The element count never passes the window capacity.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= swmm_pkg::POS_BITS'(swmm_pkg::MAX_WINDOW))
        else $error("position beyond window capacity");

    // A load or stream item keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_op == swmm_pkg::OP_LOAD || i_op == swmm_pkg::OP_STREAM))
        |=> o_stall)
        else $error("input accepted while a table update is pending");

    // The count table port is never read and written in one cycle.
    a_cnt_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cnt_we && cnt_re))
        else $error("count table read and written in the same cycle");

endmodule

/* design/swmm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
